[hw/rtl/tvpp_pkg.sv]
package tvpp_pkg;

   // value format
   localparam int VAL_W  = 32;
   localparam int FRAC_W = 16;
   // wide intermediates: products of up to three values
   localparam int WIDE_W = 4 * VAL_W;
   localparam int SQ_W   = 2 * VAL_W;
   // multiplier / divisor operand: twice a rate, or the sum of two rates
   localparam int OPB_W  = VAL_W + 2;
   localparam int ROOT_W = WIDE_W / 2;
   localparam int SREM_W = ROOT_W + 4;
   localparam int CNT_W  = $clog2(WIDE_W + 1);

   // request queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // plan status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_START_LOW  = 2'd1;
   localparam logic [1:0] ST_END_LOW    = 2'd2;
   localparam logic [1:0] ST_INVALID    = 2'd3;

   // configuration register indexes
   localparam logic CSR_ACCEL = 1'b0;
   localparam logic CSR_DECEL = 1'b1;

   typedef enum logic [2:0] {
      CLS_TRAP,
      CLS_DECEL,
      CLS_HOLD,
      CLS_ACCEL,
      CLS_INVALID
   } cls_type;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } op_type;

   typedef struct packed {
      logic [VAL_W-1:0] seg_len;
      logic [VAL_W-1:0] v_begin;
      logic [VAL_W-1:0] v_finish;
      logic [VAL_W-1:0] v_cruise;
      cls_type          cls;
   } item_type;

   typedef struct packed {
      logic             start;
      op_type           op;
      logic [WIDE_W-1:0] a;
      logic [OPB_W-1:0]  b;
   } arith_req_type;

   // saturate a wide value to the value width
   function automatic logic [VAL_W-1:0] sat(input logic [WIDE_W-1:0] x);
      logic [VAL_W-1:0] r;
      r = (|x[WIDE_W-1:VAL_W]) ? {VAL_W{1'b1}} : x[VAL_W-1:0];
      return r;
   endfunction

   // value scaled up by the fraction bits, as a dividend
   function automatic logic [WIDE_W-1:0] shq(input logic [VAL_W-1:0] x);
      logic [WIDE_W-1:0] r;
      r = WIDE_W'(x) << FRAC_W;
      return r;
   endfunction

endpackage

[hw/rtl/tvpp_arith.sv]
// Shared iterative unit: shift-add multiply, restoring divide, digit square root.
module tvpp_arith (
   input  logic                          clock,
   input  logic                          reset,
   input  tvpp_pkg::arith_req_type       req,
   output logic                          done,
   output logic [tvpp_pkg::WIDE_W-1:0]   result
);

   localparam int WIDE_W = tvpp_pkg::WIDE_W;
   localparam int OPB_W  = tvpp_pkg::OPB_W;
   localparam int ROOT_W = tvpp_pkg::ROOT_W;
   localparam int SREM_W = tvpp_pkg::SREM_W;
   localparam int CNT_W  = tvpp_pkg::CNT_W;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   tvpp_pkg::op_type    op_ff, op_in;
   logic [WIDE_W-1:0]   x_ff, x_in;
   logic [OPB_W-1:0]    y_ff, y_in;
   logic [WIDE_W-1:0]   p_ff, p_in;
   logic [OPB_W-1:0]    drem_ff, drem_in;
   logic [SREM_W-1:0]   srem_ff, srem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;

   // one step of the selected operation
   always_comb begin
      logic [OPB_W:0]    rsh;
      logic              dge;
      logic [SREM_W-1:0] sr;
      logic [SREM_W-1:0] trial;
      logic              sge;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      p_in    = p_ff;
      drem_in = drem_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      rsh     = {drem_ff, x_ff[WIDE_W-1]};
      dge     = rsh >= {1'b0, y_ff};
      sr      = {srem_ff[SREM_W-3:0], x_ff[WIDE_W-1 -: 2]};
      trial   = SREM_W'({root_ff, 2'b01});
      sge     = sr >= trial;
      if (!busy_ff && req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         x_in    = req.a;
         y_in    = req.b;
         p_in    = '0;
         drem_in = '0;
         srem_in = '0;
         root_in = '0;
         unique case (req.op)
            tvpp_pkg::OP_MUL:  cnt_in = CNT_W'(OPB_W);
            tvpp_pkg::OP_DIV:  cnt_in = CNT_W'(WIDE_W);
            tvpp_pkg::OP_SQRT: cnt_in = CNT_W'(ROOT_W);
            default:           cnt_in = CNT_W'(1);
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            tvpp_pkg::OP_MUL: begin
               if (y_ff[0]) begin
                  p_in = p_ff + x_ff;
               end
               x_in = x_ff << 1;
               y_in = y_ff >> 1;
            end
            tvpp_pkg::OP_DIV: begin
               drem_in = dge ? OPB_W'(rsh - {1'b0, y_ff}) : OPB_W'(rsh);
               x_in    = {x_ff[WIDE_W-2:0], dge};
            end
            tvpp_pkg::OP_SQRT: begin
               srem_in = sge ? sr - trial : sr;
               root_in = {root_ff[ROOT_W-2:0], sge};
               x_in    = x_ff << 2;
            end
            default: begin
               x_in = x_ff;
            end
         endcase
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= tvpp_pkg::OP_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      p_ff    <= p_in;
      drem_ff <= drem_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;

   always_comb begin
      unique case (op_ff)
         tvpp_pkg::OP_MUL:  result = p_ff;
         tvpp_pkg::OP_DIV:  result = x_ff;
         tvpp_pkg::OP_SQRT: result = WIDE_W'(root_ff);
         default:           result = '0;
      endcase
   end

endmodule

[hw/rtl/tvpp_front.sv]
// Front end: accepts segment requests, classifies them and queues them.
module tvpp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tvpp_pkg::VAL_W-1:0]   req_segment_length,
   input  logic [tvpp_pkg::VAL_W-1:0]   req_speed_begin,
   input  logic [tvpp_pkg::VAL_W-1:0]   req_speed_finish,
   input  logic [tvpp_pkg::VAL_W-1:0]   req_speed_cruise,
   input  logic [tvpp_pkg::VAL_W-1:0]   accel_rate,
   input  logic [tvpp_pkg::VAL_W-1:0]   decel_rate,
   output logic                         q_valid,
   output tvpp_pkg::item_type           q_item,
   input  logic                         q_pop
);

   localparam int QDEPTH = tvpp_pkg::QDEPTH;
   localparam int QPTR_W = tvpp_pkg::QPTR_W;

   tvpp_pkg::item_type  q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;
   tvpp_pkg::item_type  item;
   logic                push;

   // ordering of the speeds picks the plan; a zero rate makes it invalid
   always_comb begin
      item.seg_len  = req_segment_length;
      item.v_begin  = req_speed_begin;
      item.v_finish = req_speed_finish;
      item.v_cruise = req_speed_cruise;
      if (accel_rate == '0 || decel_rate == '0) begin
         item.cls = tvpp_pkg::CLS_INVALID;
      end else if (req_speed_begin < req_speed_cruise &&
                   req_speed_finish < req_speed_cruise) begin
         item.cls = tvpp_pkg::CLS_TRAP;
      end else if (req_speed_begin == req_speed_cruise &&
                   req_speed_finish < req_speed_cruise) begin
         item.cls = tvpp_pkg::CLS_DECEL;
      end else if (req_speed_begin == req_speed_cruise &&
                   req_speed_finish == req_speed_cruise) begin
         item.cls = tvpp_pkg::CLS_HOLD;
      end else if (req_speed_finish == req_speed_cruise &&
                   req_speed_begin < req_speed_cruise) begin
         item.cls = tvpp_pkg::CLS_ACCEL;
      end else begin
         item.cls = tvpp_pkg::CLS_INVALID;
      end
   end

   // queue
   assign req_stall = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = q_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= item;
      end
   end

endmodule

[hw/rtl/tvpp_back.sv]
// Back end: sequences the plan for one segment on the shared arithmetic unit.
module tvpp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  tvpp_pkg::item_type           q_item,
   output logic                         q_pop,
   input  logic [tvpp_pkg::VAL_W-1:0]   accel_rate,
   input  logic [tvpp_pkg::VAL_W-1:0]   decel_rate,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tvpp_pkg::VAL_W-1:0]   rsp_accel_duration,
   output logic [tvpp_pkg::VAL_W-1:0]   rsp_cruise_duration,
   output logic [tvpp_pkg::VAL_W-1:0]   rsp_decel_duration,
   output logic [tvpp_pkg::VAL_W-1:0]   rsp_start_speed_used,
   output logic [tvpp_pkg::VAL_W-1:0]   rsp_end_speed_used,
   output logic [1:0]                   rsp_plan_status
);

   localparam int VAL_W  = tvpp_pkg::VAL_W;
   localparam int WIDE_W = tvpp_pkg::WIDE_W;
   localparam int SQ_W   = tvpp_pkg::SQ_W;
   localparam int OPB_W  = tvpp_pkg::OPB_W;

   typedef enum logic [5:0] {
      S_IDLE,
      S_SQT, S_SQS, S_SQE, S_RA, S_RD, S_TCMP, S_T1, S_T2, S_T3,
      S_N1, S_N2, S_N3, S_N4, S_N5, S_N6, S_PCHK, S_P1, S_P3,
      S_D_SQS, S_D_SQE, S_D_R, S_D_CHK, S_D_T2, S_D_T3, S_D_M, S_D_Q, S_D_T3B,
      S_A_SQS, S_A_SQE, S_A_R, S_A_CHK, S_A_T1, S_A_T2, S_A_M, S_A_Q, S_A_T1B,
      S_H_CHK, S_H_T2, S_H_N1, S_H_N2, S_H_DV, S_H_Q, S_H_T1, S_H_T3,
      S_OUT
   } state_type;

   state_type            state_ff;
   logic                 issued_ff;
   logic [VAL_W-1:0]     d_ff, vs_ff, ve_ff, vt_ff;
   logic [SQ_W-1:0]      sq_t_ff, sq_s_ff, sq_e_ff;
   logic [SQ_W-1:0]      ramp_a_ff, ramp_d_ff;
   logic [WIDE_W-1:0]    num_ff, tmp_ff;
   logic [VAL_W-1:0]     peak_ff;
   logic [VAL_W-1:0]     t1_ff, t2_ff, t3_ff, vsu_ff, veu_ff;
   logic [1:0]           st_ff;
   logic                 rsp_valid_ff;
   logic [VAL_W-1:0]     o_t1_ff, o_t2_ff, o_t3_ff, o_vs_ff, o_ve_ff;
   logic [1:0]           o_st_ff;

   tvpp_pkg::arith_req_type areq;
   logic                    a_done;
   logic [WIDE_W-1:0]       a_res;
   logic                    uses_unit;
   logic [SQ_W:0]           both;
   logic [VAL_W-1:0]        res_sat;
   logic [OPB_W-1:0]        acc2, dec2, rsum;

   tvpp_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .req    (areq),
      .done   (a_done),
      .result (a_res)
   );

   assign both    = {1'b0, ramp_a_ff} + {1'b0, ramp_d_ff};
   assign res_sat = tvpp_pkg::sat(a_res);
   assign acc2    = OPB_W'({accel_rate, 1'b0});
   assign dec2    = OPB_W'({decel_rate, 1'b0});
   assign rsum    = OPB_W'(accel_rate) + OPB_W'(decel_rate);
   assign q_pop   = (state_ff == S_IDLE) && q_valid;

   // operation issued in each state
   always_comb begin
      uses_unit = 1'b1;
      areq.op   = tvpp_pkg::OP_DIV;
      areq.a    = '0;
      areq.b    = '0;
      unique case (state_ff)
         S_SQT: begin
            areq.op = tvpp_pkg::OP_MUL; areq.a = WIDE_W'(vt_ff); areq.b = OPB_W'(vt_ff);
         end
         S_SQS, S_D_SQS, S_A_SQS: begin
            areq.op = tvpp_pkg::OP_MUL; areq.a = WIDE_W'(vs_ff); areq.b = OPB_W'(vs_ff);
         end
         S_SQE, S_D_SQE, S_A_SQE: begin
            areq.op = tvpp_pkg::OP_MUL; areq.a = WIDE_W'(ve_ff); areq.b = OPB_W'(ve_ff);
         end
         S_RA: begin
            areq.a = WIDE_W'(sq_t_ff - sq_s_ff); areq.b = acc2;
         end
         S_RD: begin
            areq.a = WIDE_W'(sq_t_ff - sq_e_ff); areq.b = dec2;
         end
         S_T1: begin
            areq.a = tvpp_pkg::shq(vt_ff - vs_ff); areq.b = OPB_W'(accel_rate);
         end
         S_T2: begin
            areq.a = tvpp_pkg::shq(d_ff - both[VAL_W-1:0]); areq.b = OPB_W'(vt_ff);
         end
         S_T3: begin
            areq.a = tvpp_pkg::shq(vt_ff - ve_ff); areq.b = OPB_W'(decel_rate);
         end
         S_N1, S_H_N1: begin
            areq.op = tvpp_pkg::OP_MUL; areq.a = WIDE_W'(acc2); areq.b = OPB_W'(decel_rate);
         end
         S_N2, S_H_N2: begin
            areq.op = tvpp_pkg::OP_MUL; areq.a = num_ff; areq.b = OPB_W'(d_ff);
         end
         S_N3: begin
            areq.op = tvpp_pkg::OP_MUL; areq.a = WIDE_W'(sq_s_ff);
            areq.b = OPB_W'(decel_rate);
         end
         S_N4: begin
            areq.op = tvpp_pkg::OP_MUL; areq.a = WIDE_W'(sq_e_ff);
            areq.b = OPB_W'(accel_rate);
         end
         S_N5, S_H_DV: begin
            areq.a = num_ff; areq.b = rsum;
         end
         S_N6, S_H_Q: begin
            areq.op = tvpp_pkg::OP_SQRT; areq.a = tmp_ff;
         end
         S_P1, S_A_T1B: begin
            areq.a = tvpp_pkg::shq(peak_ff - vs_ff); areq.b = OPB_W'(accel_rate);
         end
         S_P3, S_D_T3B: begin
            areq.a = tvpp_pkg::shq(peak_ff - ve_ff); areq.b = OPB_W'(decel_rate);
         end
         S_D_R: begin
            areq.a = WIDE_W'(sq_s_ff - sq_e_ff); areq.b = dec2;
         end
         S_D_T2: begin
            areq.a = tvpp_pkg::shq(d_ff - ramp_d_ff[VAL_W-1:0]); areq.b = OPB_W'(vs_ff);
         end
         S_D_T3: begin
            areq.a = tvpp_pkg::shq(vs_ff - ve_ff); areq.b = OPB_W'(decel_rate);
         end
         S_D_M: begin
            areq.op = tvpp_pkg::OP_MUL; areq.a = WIDE_W'(dec2); areq.b = OPB_W'(d_ff);
         end
         S_D_Q: begin
            areq.op = tvpp_pkg::OP_SQRT; areq.a = WIDE_W'(sq_e_ff) + tmp_ff;
         end
         S_A_R: begin
            areq.a = WIDE_W'(sq_e_ff - sq_s_ff); areq.b = acc2;
         end
         S_A_T1: begin
            areq.a = tvpp_pkg::shq(ve_ff - vs_ff); areq.b = OPB_W'(accel_rate);
         end
         S_A_T2: begin
            areq.a = tvpp_pkg::shq(d_ff - ramp_a_ff[VAL_W-1:0]); areq.b = OPB_W'(ve_ff);
         end
         S_A_M: begin
            areq.op = tvpp_pkg::OP_MUL; areq.a = WIDE_W'(acc2); areq.b = OPB_W'(d_ff);
         end
         S_A_Q: begin
            areq.op = tvpp_pkg::OP_SQRT; areq.a = WIDE_W'(sq_s_ff) + tmp_ff;
         end
         S_H_T2: begin
            areq.a = tvpp_pkg::shq(d_ff); areq.b = OPB_W'(vs_ff);
         end
         S_H_T1: begin
            areq.a = tvpp_pkg::shq(peak_ff); areq.b = OPB_W'(accel_rate);
         end
         S_H_T3: begin
            areq.a = tvpp_pkg::shq(peak_ff); areq.b = OPB_W'(decel_rate);
         end
         default: begin
            uses_unit = 1'b0;
         end
      endcase
      areq.start = uses_unit && !issued_ff;
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response valid: set when a plan is loaded, cleared once taken
         if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (uses_unit) begin
            if (a_done) begin
               issued_ff <= 1'b0;
            end else if (!issued_ff) begin
               issued_ff <= 1'b1;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  d_ff   <= q_item.seg_len;
                  vs_ff  <= q_item.v_begin;
                  ve_ff  <= q_item.v_finish;
                  vt_ff  <= q_item.v_cruise;
                  t1_ff  <= '0;
                  t2_ff  <= '0;
                  t3_ff  <= '0;
                  vsu_ff <= q_item.v_begin;
                  veu_ff <= q_item.v_finish;
                  st_ff  <= tvpp_pkg::ST_OK;
                  unique case (q_item.cls)
                     tvpp_pkg::CLS_TRAP:  state_ff <= S_SQT;
                     tvpp_pkg::CLS_DECEL: state_ff <= S_D_SQS;
                     tvpp_pkg::CLS_HOLD:  state_ff <= S_H_CHK;
                     tvpp_pkg::CLS_ACCEL: state_ff <= S_A_SQS;
                     default: begin
                        vsu_ff   <= '0;
                        veu_ff   <= '0;
                        st_ff    <= tvpp_pkg::ST_INVALID;
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            // trapezoid
            S_SQT: if (a_done) begin sq_t_ff <= a_res[SQ_W-1:0]; state_ff <= S_SQS; end
            S_SQS: if (a_done) begin sq_s_ff <= a_res[SQ_W-1:0]; state_ff <= S_SQE; end
            S_SQE: if (a_done) begin sq_e_ff <= a_res[SQ_W-1:0]; state_ff <= S_RA; end
            S_RA:  if (a_done) begin ramp_a_ff <= a_res[SQ_W-1:0]; state_ff <= S_RD; end
            S_RD:  if (a_done) begin ramp_d_ff <= a_res[SQ_W-1:0]; state_ff <= S_TCMP; end
            S_TCMP: begin
               state_ff <= ((SQ_W+1)'(d_ff) >= both) ? S_T1 : S_N1;
            end
            S_T1: if (a_done) begin t1_ff <= res_sat; state_ff <= S_T2; end
            S_T2: if (a_done) begin t2_ff <= res_sat; state_ff <= S_T3; end
            S_T3: if (a_done) begin t3_ff <= res_sat; state_ff <= S_OUT; end
            // triangle peak
            S_N1: if (a_done) begin num_ff <= a_res; state_ff <= S_N2; end
            S_N2: if (a_done) begin num_ff <= a_res; state_ff <= S_N3; end
            S_N3: if (a_done) begin num_ff <= num_ff + a_res; state_ff <= S_N4; end
            S_N4: if (a_done) begin num_ff <= num_ff + a_res; state_ff <= S_N5; end
            S_N5: if (a_done) begin tmp_ff <= a_res; state_ff <= S_N6; end
            S_N6: if (a_done) begin peak_ff <= res_sat; state_ff <= S_PCHK; end
            S_PCHK: begin
               if (vs_ff < peak_ff && ve_ff < peak_ff) begin
                  state_ff <= S_P1;
               end else if (vs_ff > ve_ff) begin
                  state_ff <= S_D_SQS;
               end else if (vs_ff == ve_ff) begin
                  state_ff <= S_H_CHK;
               end else begin
                  state_ff <= S_A_SQS;
               end
            end
            S_P1: if (a_done) begin t1_ff <= res_sat; state_ff <= S_P3; end
            S_P3: if (a_done) begin t3_ff <= res_sat; state_ff <= S_OUT; end
            // decelerate from the start speed
            S_D_SQS: if (a_done) begin sq_s_ff <= a_res[SQ_W-1:0]; state_ff <= S_D_SQE; end
            S_D_SQE: if (a_done) begin sq_e_ff <= a_res[SQ_W-1:0]; state_ff <= S_D_R; end
            S_D_R:   if (a_done) begin ramp_d_ff <= a_res[SQ_W-1:0]; state_ff <= S_D_CHK; end
            S_D_CHK: begin
               state_ff <= (ramp_d_ff <= SQ_W'(d_ff)) ? S_D_T2 : S_D_M;
            end
            S_D_T2: if (a_done) begin t2_ff <= res_sat; state_ff <= S_D_T3; end
            S_D_T3: if (a_done) begin t3_ff <= res_sat; state_ff <= S_OUT; end
            S_D_M:  if (a_done) begin tmp_ff <= a_res; state_ff <= S_D_Q; end
            S_D_Q:  if (a_done) begin peak_ff <= res_sat; state_ff <= S_D_T3B; end
            S_D_T3B: if (a_done) begin
               t3_ff    <= res_sat;
               vsu_ff   <= peak_ff;
               st_ff    <= tvpp_pkg::ST_START_LOW;
               state_ff <= S_OUT;
            end
            // accelerate to the end speed
            S_A_SQS: if (a_done) begin sq_s_ff <= a_res[SQ_W-1:0]; state_ff <= S_A_SQE; end
            S_A_SQE: if (a_done) begin sq_e_ff <= a_res[SQ_W-1:0]; state_ff <= S_A_R; end
            S_A_R:   if (a_done) begin ramp_a_ff <= a_res[SQ_W-1:0]; state_ff <= S_A_CHK; end
            S_A_CHK: begin
               state_ff <= (ramp_a_ff <= SQ_W'(d_ff)) ? S_A_T1 : S_A_M;
            end
            S_A_T1: if (a_done) begin t1_ff <= res_sat; state_ff <= S_A_T2; end
            S_A_T2: if (a_done) begin t2_ff <= res_sat; state_ff <= S_OUT; end
            S_A_M:  if (a_done) begin tmp_ff <= a_res; state_ff <= S_A_Q; end
            S_A_Q:  if (a_done) begin peak_ff <= res_sat; state_ff <= S_A_T1B; end
            S_A_T1B: if (a_done) begin
               t1_ff    <= res_sat;
               veu_ff   <= peak_ff;
               st_ff    <= tvpp_pkg::ST_END_LOW;
               state_ff <= S_OUT;
            end
            // hold speed, or rest-to-rest triangle
            S_H_CHK: begin
               state_ff <= (vs_ff != '0) ? S_H_T2 : S_H_N1;
            end
            S_H_T2: if (a_done) begin t2_ff <= res_sat; state_ff <= S_OUT; end
            S_H_N1: if (a_done) begin num_ff <= a_res; state_ff <= S_H_N2; end
            S_H_N2: if (a_done) begin num_ff <= a_res; state_ff <= S_H_DV; end
            S_H_DV: if (a_done) begin tmp_ff <= a_res; state_ff <= S_H_Q; end
            S_H_Q:  if (a_done) begin peak_ff <= res_sat; state_ff <= S_H_T1; end
            S_H_T1: if (a_done) begin t1_ff <= res_sat; state_ff <= S_H_T3; end
            S_H_T3: if (a_done) begin t3_ff <= res_sat; state_ff <= S_OUT; end
            // hand the plan to the output register
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  o_t1_ff      <= t1_ff;
                  o_t2_ff      <= t2_ff;
                  o_t3_ff      <= t3_ff;
                  o_vs_ff      <= vsu_ff;
                  o_ve_ff      <= veu_ff;
                  o_st_ff      <= st_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_accel_duration   = o_t1_ff;
   assign rsp_cruise_duration  = o_t2_ff;
   assign rsp_decel_duration   = o_t3_ff;
   assign rsp_start_speed_used = o_vs_ff;
   assign rsp_end_speed_used   = o_ve_ff;
   assign rsp_plan_status      = o_st_ff;

endmodule

[hw/rtl/trapezoid_velocity_profile_planner.sv]
// Trapezoidal velocity profile planner, unsigned Q16.16. Each request is one
// motion segment (length, start, end and cruise speed); the response gives the
// accelerate, cruise and decelerate times, the start and end speeds actually
// used and a status (ok, start lowered, end lowered, invalid). Requests are
// classified and queued (four deep) on arrival, so the request side keeps
// accepting while the planner works, until the queue is full. Planning runs
// on one shared iterative unit that does one multiply, divide or square root
// at a time; the sequencer waits on it for each arithmetic step. The back end
// takes a new request only after the last plan went to the output register.
// A finished plan sits in an output register while the next one is computed.
// Acceleration and deceleration are written through the csr port; the user
// must write them only while idle, and the block itself does not enforce it.
module trapezoid_velocity_profile_planner (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tvpp_pkg::VAL_W-1:0]    req_segment_length,
   input  logic [tvpp_pkg::VAL_W-1:0]    req_speed_begin,
   input  logic [tvpp_pkg::VAL_W-1:0]    req_speed_finish,
   input  logic [tvpp_pkg::VAL_W-1:0]    req_speed_cruise,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tvpp_pkg::VAL_W-1:0]    rsp_accel_duration,
   output logic [tvpp_pkg::VAL_W-1:0]    rsp_cruise_duration,
   output logic [tvpp_pkg::VAL_W-1:0]    rsp_decel_duration,
   output logic [tvpp_pkg::VAL_W-1:0]    rsp_start_speed_used,
   output logic [tvpp_pkg::VAL_W-1:0]    rsp_end_speed_used,
   output logic [1:0]                    rsp_plan_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [tvpp_pkg::VAL_W-1:0]    csr_wdata
);

   localparam int VAL_W = tvpp_pkg::VAL_W;

   logic [VAL_W-1:0]    accel_ff, decel_ff;
   logic                q_valid, q_pop;
   tvpp_pkg::item_type  q_item;

   // rate registers, reset to 1.0
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= VAL_W'(1) << tvpp_pkg::FRAC_W;
         decel_ff <= VAL_W'(1) << tvpp_pkg::FRAC_W;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tvpp_pkg::CSR_ACCEL: accel_ff <= csr_wdata;
            tvpp_pkg::CSR_DECEL: decel_ff <= csr_wdata;
            default:             accel_ff <= accel_ff;
         endcase
      end
   end

   tvpp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_segment_length (req_segment_length),
      .req_speed_begin    (req_speed_begin),
      .req_speed_finish   (req_speed_finish),
      .req_speed_cruise   (req_speed_cruise),
      .accel_rate         (accel_ff),
      .decel_rate         (decel_ff),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   tvpp_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_item               (q_item),
      .q_pop                (q_pop),
      .accel_rate           (accel_ff),
      .decel_rate           (decel_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_accel_duration   (rsp_accel_duration),
      .rsp_cruise_duration  (rsp_cruise_duration),
      .rsp_decel_duration   (rsp_decel_duration),
      .rsp_start_speed_used (rsp_start_speed_used),
      .rsp_end_speed_used   (rsp_end_speed_used),
      .rsp_plan_status      (rsp_plan_status)
   );

endmodule
